// ===== src/r256cbc_pkg.sv =====
// Shared types, constants and byte-level cipher functions for the Rijndael-256 CBC block.
package r256cbc_pkg;

    localparam int ROUND_COUNT = 14;
    localparam int CNT_W = $clog2(ROUND_COUNT + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR  = 3'd5;

    // Round constants of the first and the last schedule step.
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] RCON_LAST  = 8'h4d;
    localparam logic [7:0] AFF_CONST  = 8'h63;

    localparam int ROW_SHIFT [4] = '{0, 1, 3, 4};

    // Standard substitution table with entry 0 in the top byte.
    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    typedef struct packed {
        logic prep_load;
        logic key_step;
        logic prep_last;
        logic blk_load;
        logic cv_load;
        logic round_en;
        logic round_last;
        logic emit;
    } cmd_t;

    function automatic logic [7:0] sbox_raw(input logic [7:0] x);
        return SBOX_BITS[(11'd2047 - {x, 3'b000}) -: 8];
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] inv_aff(input logic [7:0] y);
        return rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6);
    endfunction

    function automatic logic [7:0] sub_fwd(input logic [7:0] x, input logic [7:0] g);
        return sbox_raw(x) ^ AFF_CONST ^ g;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] ixtime(input logic [7:0] y);
        return y[0] ? (((y ^ 8'h1b) >> 1) | 8'h80) : (y >> 1);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w, input logic [7:0] g);
        return {sub_fwd(w[31:24], g), sub_fwd(w[23:16], g),
                sub_fwd(w[15:8], g), sub_fwd(w[7:0], g)};
    endfunction

    function automatic logic [31:0] rot_word(input logic [31:0] w);
        return {w[7:0], w[31:8]};
    endfunction

    function automatic logic [255:0] key_fwd(input logic [255:0] k, input logic [7:0] rc,
                                             input logic [7:0] g);
        logic [31:0] n [8];
        n[0] = k[31:0] ^ sub_word(rot_word(k[255:224]), g) ^ {24'd0, rc};
        n[1] = k[63:32] ^ n[0];
        n[2] = k[95:64] ^ n[1];
        n[3] = k[127:96] ^ n[2];
        n[4] = k[159:128] ^ sub_word(n[3], g);
        n[5] = k[191:160] ^ n[4];
        n[6] = k[223:192] ^ n[5];
        n[7] = k[255:224] ^ n[6];
        return {n[7], n[6], n[5], n[4], n[3], n[2], n[1], n[0]};
    endfunction

    function automatic logic [255:0] key_inv(input logic [255:0] k, input logic [7:0] rc,
                                             input logic [7:0] g);
        logic [31:0] w [8];
        w[7] = k[255:224] ^ k[223:192];
        w[6] = k[223:192] ^ k[191:160];
        w[5] = k[191:160] ^ k[159:128];
        w[4] = k[159:128] ^ sub_word(k[127:96], g);
        w[3] = k[127:96] ^ k[95:64];
        w[2] = k[95:64] ^ k[63:32];
        w[1] = k[63:32] ^ k[31:0];
        w[0] = k[31:0] ^ sub_word(rot_word(w[7]), g) ^ {24'd0, rc};
        return {w[7], w[6], w[5], w[4], w[3], w[2], w[1], w[0]};
    endfunction

endpackage

// ===== src/r256cbc_ctrl.sv =====
// Sequencer for key preparation, cipher rounds and result hand-off.
module r256cbc_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [r256cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output r256cbc_pkg::cmd_t                   cmd
);

    typedef enum logic [3:0] {
        ST_PREP  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [r256cbc_pkg::CNT_W-1:0] CNT_LAST =
        r256cbc_pkg::CNT_W'(r256cbc_pkg::ROUND_COUNT);
    localparam logic [r256cbc_pkg::CNT_W-1:0] CNT_W1 = r256cbc_pkg::CNT_W'(1);

    state_t                          state_reg, state_next;
    logic [r256cbc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            rekey;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    assign rekey = cfg_wr_en && (cfg_index == r256cbc_pkg::REG_KEY0 ||
                                 cfg_index == r256cbc_pkg::REG_KEY1 ||
                                 cfg_index == r256cbc_pkg::REG_KEY2 ||
                                 cfg_index == r256cbc_pkg::REG_KEY3 ||
                                 cfg_index == r256cbc_pkg::REG_GEN);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_PREP: begin
                cmd.prep_load = (cnt_reg == '0);
                cmd.key_step  = (cnt_reg != '0);
                cmd.prep_last = (cnt_reg == CNT_LAST);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode) begin
                        cmd.blk_load = 1'b1;
                        state_next   = ST_ROUND;
                        cnt_next     = CNT_W1;
                    end else begin
                        cmd.cv_load = 1'b1;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_en   = 1'b1;
                cmd.round_last = (cnt_reg == CNT_LAST);
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default: begin
                state_next = ST_PREP;
                cnt_next   = '0;
            end
        endcase
        if (rekey) begin
            state_next = ST_PREP;
            cnt_next   = '0;
        end
    end

    assign m_valid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_PREP;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("State register is not one-hot.");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_LAST)
        else $error("Round counter ran past the last round.");

    a_block_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode && !rekey |=> state_reg == ST_ROUND)
        else $error("A block transfer did not start the rounds.");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid_reg || m_ready))
        else $error("Result overwrote a pending transfer.");

endmodule

// ===== src/r256cbc_datapath.sv =====
// Configuration registers, round state, on-the-fly key schedule and output register.
module r256cbc_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [r256cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                         cfg_wr_data,
    input  r256cbc_pkg::cmd_t                   cmd,
    input  logic [255:0]                        blk_in,
    output logic [255:0]                        blk_out
);

    logic [255:0] key_reg;
    logic [7:0]   gen_reg;
    logic         dir_reg;
    logic [255:0] cv_reg, cv_next;
    logic [255:0] blk_reg;
    logic [255:0] st_reg, st_next;
    logic [255:0] rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [255:0] kl_reg;
    logic [255:0] out_reg;
    logic [255:0] rk_fwd, rk_inv, rnd_enc, rnd_dec;

    function automatic logic [255:0] enc_round(input logic [255:0] s, input logic [7:0] g,
                                               input logic last);
        logic [255:0] sb, sr, mc;
        logic [7:0] a [4];
        for (int i = 0; i < 32; i++) begin
            sb[i*8 +: 8] = r256cbc_pkg::sub_fwd(s[i*8 +: 8], g);
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 8; c++) begin
                sr[(8*r + c)*8 +: 8] =
                    sb[(8*r + ((c + r256cbc_pkg::ROW_SHIFT[r]) % 8))*8 +: 8];
            end
        end
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = sr[(8*r + c)*8 +: 8];
            end
            for (int r = 0; r < 4; r++) begin
                mc[(8*r + c)*8 +: 8] = r256cbc_pkg::xtime(a[r])
                    ^ r256cbc_pkg::xtime(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
                    ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
            end
        end
        return last ? sr : mc;
    endfunction

    function automatic logic [255:0] dec_round(input logic [255:0] s, input logic [255:0] k,
                                               input logic [7:0] g, input logic last);
        logic [255:0] sr, sb, mc;
        logic [7:0] a [4];
        logic [7:0] x2, x4, x8, y2, y4, y8, z2, z4, z8, w2, w4, w8;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 8; c++) begin
                sr[(8*r + ((c + r256cbc_pkg::ROW_SHIFT[r]) % 8))*8 +: 8] =
                    s[(8*r + c)*8 +: 8];
            end
        end
        for (int i = 0; i < 32; i++) begin
            sb[i*8 +: 8] = r256cbc_pkg::inv_aff(
                r256cbc_pkg::sbox_raw(r256cbc_pkg::inv_aff(sr[i*8 +: 8] ^ g))
                ^ r256cbc_pkg::AFF_CONST) ^ k[i*8 +: 8];
        end
        for (int c = 0; c < 8; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = sb[(8*r + c)*8 +: 8];
            end
            for (int r = 0; r < 4; r++) begin
                x2 = r256cbc_pkg::xtime(a[r]);
                x4 = r256cbc_pkg::xtime(x2);
                x8 = r256cbc_pkg::xtime(x4);
                y2 = r256cbc_pkg::xtime(a[(r + 1) % 4]);
                y4 = r256cbc_pkg::xtime(y2);
                y8 = r256cbc_pkg::xtime(y4);
                z2 = r256cbc_pkg::xtime(a[(r + 2) % 4]);
                z4 = r256cbc_pkg::xtime(z2);
                z8 = r256cbc_pkg::xtime(z4);
                w2 = r256cbc_pkg::xtime(a[(r + 3) % 4]);
                w4 = r256cbc_pkg::xtime(w2);
                w8 = r256cbc_pkg::xtime(w4);
                mc[(8*r + c)*8 +: 8] = (x8 ^ x4 ^ x2)
                    ^ (y8 ^ y2 ^ a[(r + 1) % 4])
                    ^ (z8 ^ z4 ^ a[(r + 2) % 4])
                    ^ (w8 ^ a[(r + 3) % 4]);
            end
        end
        return last ? sb : mc;
    endfunction

    assign rk_fwd  = r256cbc_pkg::key_fwd(rk_reg, rc_reg, gen_reg);
    assign rk_inv  = r256cbc_pkg::key_inv(rk_reg, rc_reg, gen_reg);
    assign rnd_enc = enc_round(st_reg, gen_reg, cmd.round_last) ^ rk_reg;
    assign rnd_dec = dec_round(st_reg, rk_reg, gen_reg, cmd.round_last);

    always_comb begin
        st_next = st_reg;
        rk_next = rk_reg;
        rc_next = rc_reg;
        cv_next = cv_reg;
        if (cmd.prep_load) begin
            rk_next = key_reg;
            rc_next = r256cbc_pkg::RCON_FIRST;
        end else if (cmd.key_step) begin
            rk_next = rk_fwd;
            rc_next = r256cbc_pkg::xtime(rc_reg);
        end else if (cmd.blk_load) begin
            if (dir_reg) begin
                st_next = blk_in ^ cv_reg ^ key_reg;
                rk_next = r256cbc_pkg::key_fwd(key_reg, r256cbc_pkg::RCON_FIRST, gen_reg);
                rc_next = r256cbc_pkg::xtime(r256cbc_pkg::RCON_FIRST);
            end else begin
                st_next = blk_in ^ kl_reg;
                rk_next = r256cbc_pkg::key_inv(kl_reg, r256cbc_pkg::RCON_LAST, gen_reg);
                rc_next = r256cbc_pkg::ixtime(r256cbc_pkg::RCON_LAST);
            end
        end else if (cmd.round_en) begin
            st_next = dir_reg ? rnd_enc : rnd_dec;
            rk_next = dir_reg ? rk_fwd : rk_inv;
            rc_next = dir_reg ? r256cbc_pkg::xtime(rc_reg) : r256cbc_pkg::ixtime(rc_reg);
        end
        if (cmd.cv_load) begin
            cv_next = blk_in;
        end else if (cmd.emit) begin
            cv_next = dir_reg ? st_reg : blk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
            gen_reg <= 8'd3;
            dir_reg <= 1'b1;
            cv_reg  <= '0;
        end else begin
            cv_reg <= cv_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    r256cbc_pkg::REG_KEY0: key_reg[63:0]    <= cfg_wr_data;
                    r256cbc_pkg::REG_KEY1: key_reg[127:64]  <= cfg_wr_data;
                    r256cbc_pkg::REG_KEY2: key_reg[191:128] <= cfg_wr_data;
                    r256cbc_pkg::REG_KEY3: key_reg[255:192] <= cfg_wr_data;
                    r256cbc_pkg::REG_GEN:  gen_reg          <= cfg_wr_data[7:0];
                    r256cbc_pkg::REG_DIR:  dir_reg          <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
        rk_reg <= rk_next;
        rc_reg <= rc_next;
        if (cmd.blk_load) begin
            blk_reg <= blk_in;
        end
        if (cmd.prep_last) begin
            kl_reg <= rk_fwd;
        end
        if (cmd.emit) begin
            out_reg <= dir_reg ? st_reg : (st_reg ^ cv_reg);
        end
    end

    assign blk_out = out_reg;

endmodule

// ===== src/rijndael256_cbc_block_cipher.sv =====
// Rijndael-256 CBC block cipher top level.
// A block transfer runs the rounds in ST_ROUND; then ST_EMIT, which waits while an earlier
// result is pending, loads the output register and raises m_valid. s_ready is low meanwhile,
// so the shared round unit takes one block at a time. A chaining-value load transfer gives
// no result. After reset and each key or generator write, a key schedule walk finds the
// last round key with s_ready low; reset zeroes key and chain, sets generator 3 and encrypt.
module rijndael256_cbc_block_cipher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [63:0] s_row0,
    input  logic [63:0] s_row1,
    input  logic [63:0] s_row2,
    input  logic [63:0] s_row3,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_row0,
    output logic [63:0] m_out_row1,
    output logic [63:0] m_out_row2,
    output logic [63:0] m_out_row3
);

    r256cbc_pkg::cmd_t cmd;
    logic [255:0]      blk_out;

    r256cbc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    r256cbc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .blk_in      ({s_row3, s_row2, s_row1, s_row0}),
        .blk_out     (blk_out)
    );

    assign m_out_row0 = blk_out[63:0];
    assign m_out_row1 = blk_out[127:64];
    assign m_out_row2 = blk_out[191:128];
    assign m_out_row3 = blk_out[255:192];

endmodule

// ===== tb/r256cbc_checker.sv =====
// Scoreboard for the Rijndael-256 CBC block: tracks configuration, predicts and compares results.
module r256cbc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [63:0] s_row0,
    input  logic [63:0] s_row1,
    input  logic [63:0] s_row2,
    input  logic [63:0] s_row3,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_out_row0,
    input  logic [63:0] m_out_row1,
    input  logic [63:0] m_out_row2,
    input  logic [63:0] m_out_row3,
    output int          fail_count,
    output int          blocks_checked,
    output int          blocks_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK_BYTES = 32;
    localparam int ROUNDS = r256cbc_pkg::ROUND_COUNT;
    localparam int SCHED_BYTES = BLK_BYTES * (ROUNDS + 1);

    logic [7:0]   exp_t [256];
    logic [7:0]   log_t [256];
    logic [7:0]   fwd_box [256];
    logic [7:0]   inv_box [256];
    logic [7:0]   sched [SCHED_BYTES];
    logic [7:0]   blk [BLK_BYTES];
    logic [63:0]  key_shadow [4];
    logic [7:0]   gen_shadow;
    logic         encrypt_sel;
    logic [255:0] chain_value;
    logic [255:0] expected_blocks [$];

    function automatic logic [7:0] poly_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int n = 0; n < 8; n++) begin
            if (b[0]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic logic [7:0] fmul(logic [7:0] a, logic [7:0] b);
        int idx;
        if (a == 8'h00) return 8'h00;
        idx = (int'(log_t[a]) + int'(log_t[b])) % 255;
        return exp_t[idx];
    endfunction

    function automatic void build_tables();
        logic [7:0] inv, s, x;
        for (int c = 0; c < 256; c++) begin
            log_t[c] = 8'h00;
            inv_box[c] = 8'h00;
        end
        exp_t[0] = 8'h01;
        for (int c = 1; c < 256; c++) begin
            exp_t[c] = poly_mul(exp_t[c-1], gen_shadow);
            log_t[exp_t[c]] = c[7:0];
        end
        for (int c = 0; c < 256; c++) begin
            inv = (c == 0) ? 8'h00 : exp_t[255 - int'(log_t[c])];
            s = inv;
            x = inv;
            for (int n = 0; n < 4; n++) begin
                s = {s[6:0], s[7]};
                x ^= s;
            end
            x ^= gen_shadow;
            fwd_box[c] = x;
            inv_box[x] = c[7:0];
        end
    endfunction

    function automatic void derive_schedule();
        logic [7:0] t [4];
        logic [7:0] f, rcon;
        rcon = 8'h01;
        for (int c = 0; c < BLK_BYTES; c++) sched[c] = key_shadow[c >> 3][8*(c & 7) +: 8];
        for (int c = BLK_BYTES; c < SCHED_BYTES; c += 4) begin
            for (int a = 0; a < 4; a++) t[a] = sched[c - 4 + a];
            if (c % BLK_BYTES == 0) begin
                f = t[0];
                t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = f;
                for (int a = 0; a < 4; a++) t[a] = fwd_box[t[a]];
                t[0] ^= rcon;
                rcon = fmul(rcon, 8'h02);
            end else if (c % BLK_BYTES == 16) begin
                for (int a = 0; a < 4; a++) t[a] = fwd_box[t[a]];
            end
            for (int a = 0; a < 4; a++) sched[c + a] = sched[c + a - BLK_BYTES] ^ t[a];
        end
    endfunction

    function automatic void add_round_key(int rnd);
        for (int i = 0; i < BLK_BYTES; i++) blk[i] ^= sched[rnd * BLK_BYTES + i];
    endfunction

    function automatic void substitute(logic inverse);
        for (int i = 0; i < BLK_BYTES; i++) blk[i] = inverse ? inv_box[blk[i]] : fwd_box[blk[i]];
    endfunction

    function automatic void rotate_rows(logic inverse);
        logic [7:0] old [8];
        int m;
        for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 8; c++) old[c] = blk[8*r + c];
            for (int c = 0; c < 8; c++) begin
                m = (c + r256cbc_pkg::ROW_SHIFT[r]) & 7;
                if (inverse) blk[8*r + m] = old[c];
                else blk[8*r + c] = old[m];
            end
        end
    endfunction

    function automatic void mix(logic inverse);
        logic [7:0] a [4];
        logic [7:0] coef [4];
        logic [7:0] v;
        if (inverse) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int col = 0; col < 8; col++) begin
            for (int r = 0; r < 4; r++) a[r] = blk[8*r + col];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= fmul(a[(r + k) & 3], coef[k]);
                blk[8*r + col] = v;
            end
        end
    endfunction

    function automatic void encrypt_blk();
        add_round_key(0);
        for (int i = 1; i < ROUNDS; i++) begin
            substitute(1'b0);
            rotate_rows(1'b0);
            mix(1'b0);
            add_round_key(i);
        end
        substitute(1'b0);
        rotate_rows(1'b0);
        add_round_key(ROUNDS);
    endfunction

    function automatic void decrypt_blk();
        add_round_key(ROUNDS);
        rotate_rows(1'b1);
        for (int i = ROUNDS - 1; i > 0; i--) begin
            substitute(1'b1);
            add_round_key(i);
            mix(1'b1);
            rotate_rows(1'b1);
        end
        substitute(1'b1);
        add_round_key(0);
    endfunction

    function automatic logic [255:0] cbc_step(logic [255:0] data);
        logic [255:0] res;
        for (int i = 0; i < BLK_BYTES; i++) blk[i] = data[8*i +: 8];
        if (encrypt_sel) begin
            for (int i = 0; i < BLK_BYTES; i++) blk[i] ^= chain_value[8*i +: 8];
            encrypt_blk();
            for (int i = 0; i < BLK_BYTES; i++) res[8*i +: 8] = blk[i];
            chain_value = res;
        end else begin
            decrypt_blk();
            for (int i = 0; i < BLK_BYTES; i++) res[8*i +: 8] = blk[i] ^ chain_value[8*i +: 8];
            chain_value = data;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [255:0] exp_blk, got_blk;
        logic [255:0] in_blk;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_shadow[i] = 64'd0;
            gen_shadow = 8'd3;
            encrypt_sel = 1'b1;
            chain_value = '0;
            build_tables();
            derive_schedule();
            expected_blocks.delete();
            fail_count = 0;
            blocks_checked = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    r256cbc_pkg::REG_KEY0, r256cbc_pkg::REG_KEY1,
                    r256cbc_pkg::REG_KEY2, r256cbc_pkg::REG_KEY3: begin
                        key_shadow[cfg_index[1:0]] = cfg_wr_data;
                        derive_schedule();
                    end
                    r256cbc_pkg::REG_GEN: begin
                        gen_shadow = cfg_wr_data[7:0];
                        build_tables();
                        derive_schedule();
                    end
                    r256cbc_pkg::REG_DIR: encrypt_sel = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got_blk = {m_out_row3, m_out_row2, m_out_row1, m_out_row0};
                if (expected_blocks.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result transfer: %h", got_blk);
                end else begin
                    exp_blk = expected_blocks.pop_front();
                    blocks_checked++;
                    for (int r = 0; r < 4; r++) begin
                        if (got_blk[64*r +: 64] !== exp_blk[64*r +: 64]) begin
                            fail_count++;
                            if (fail_count <= 10)
                                $display("Mismatch on out_row%0d: expected %h, got %h",
                                         r, exp_blk[64*r +: 64], got_blk[64*r +: 64]);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_blk = {s_row3, s_row2, s_row1, s_row0};
                if (!s_mode) chain_value = in_blk;
                else expected_blocks.push_back(cbc_step(in_blk));
            end
        end
        blocks_pending = expected_blocks.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top-level testbench for the Rijndael-256 CBC block: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE = 24;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [63:0] s_row0, s_row1, s_row2, s_row3;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_row0, m_out_row1, m_out_row2, m_out_row3;
    int          fail_count, blocks_checked, blocks_pending;
    int          cycle_count = 0;
    int          blocks_sent, loads_sent;
    logic        gaps_on;

    rijndael256_cbc_block_cipher DUT (.*);

    r256cbc_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= (gaps_on && $urandom_range(99) < 16) ? 1'b0 : 1'b1;
    end

    function automatic bit generator_ok(logic [7:0] g);
        logic [7:0] e, a, b, p;
        e = 8'h01;
        for (int c = 1; c < 255; c++) begin
            a = e;
            b = g;
            p = 8'h00;
            for (int n = 0; n < 8; n++) begin
                if (b[0]) p ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
                b = b >> 1;
            end
            e = p;
            if (e == 8'h01 || e == 8'h00) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_generator();
        logic [7:0] g;
        do g = 8'($urandom_range(255, 1)); while (!generator_ok(g));
        return g;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic reg_write_done();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(logic mode, logic [63:0] r0, logic [63:0] r1,
                             logic [63:0] r2, logic [63:0] r3);
        while (gaps_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_row0 <= r0;
        s_row1 <= r1;
        s_row2 <= r2;
        s_row3 <= r3;
        do @(posedge aclk); while (!s_ready);
        if (mode) blocks_sent++;
        else loads_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blocks_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_item(int pct_load);
        send_item($urandom_range(99) < pct_load ? 1'b0 : 1'b1,
                  rand64(), rand64(), rand64(), rand64());
    endtask

    initial begin
        logic [7:0] top_gen;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        {s_row0, s_row1, s_row2, s_row3} = '0;
        blocks_sent = 0;
        loads_sent = 0;
        gaps_on = 1'b1;
        top_gen = 8'hff;
        while (!generator_ok(top_gen)) top_gen--;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(posedge aclk);

        // Reset configuration: zero key, generator 3, encryption, zero chain.
        send_item(1'b1, '0, '0, '0, '0);
        send_item(1'b1, '1, '1, '1, '1);
        send_item(1'b0, '1, '1, '1, '1);
        send_item(1'b1, 64'h0123456789abcdef, '0, '1, 64'h8000000000000001);
        drain();

        reg_write(r256cbc_pkg::REG_DIR, 64'd0);
        reg_write_done();
        send_item(1'b0, '0, '0, '0, '0);
        send_item(1'b1, '1, '1, '1, '1);
        send_item(1'b1, '0, '0, '0, '0);
        send_item(1'b1, 64'hdeadbeefcafef00d, '1, '0, 64'h5555aaaa5555aaaa);
        drain();

        reg_write(r256cbc_pkg::REG_KEY0, '1);
        reg_write(r256cbc_pkg::REG_KEY1, '1);
        reg_write(r256cbc_pkg::REG_KEY2, '1);
        reg_write(r256cbc_pkg::REG_KEY3, '1);
        reg_write(r256cbc_pkg::REG_GEN, {56'd0, top_gen});
        reg_write(r256cbc_pkg::REG_DIR, 64'd1);
        reg_write(REG_SPARE_LO, '1);
        reg_write(REG_SPARE_HI, '0);
        reg_write_done();
        send_item(1'b1, '0, '0, '0, '0);
        send_item(1'b1, '1, '1, '1, '1);
        send_item(1'b0, 64'haaaaaaaaaaaaaaaa, '0, '1, 64'h5555555555555555);
        send_item(1'b1, '0, '1, '0, '1);
        drain();

        reg_write(r256cbc_pkg::REG_DIR, 64'd0);
        reg_write(r256cbc_pkg::REG_GEN, {56'd0, 8'd3});
        reg_write_done();
        send_item(1'b1, '1, '0, '1, '0);
        send_item(1'b1, '0, '0, '0, '0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            reg_write(r256cbc_pkg::REG_KEY0, rand64());
            reg_write(r256cbc_pkg::REG_KEY1, rand64());
            reg_write(r256cbc_pkg::REG_KEY2, rand64());
            reg_write(r256cbc_pkg::REG_KEY3, rand64());
            reg_write(r256cbc_pkg::REG_GEN, {56'd0, random_generator()});
            reg_write(r256cbc_pkg::REG_DIR, {63'd0, 1'($urandom_range(1))});
            reg_write_done();
            gaps_on = (phase != 3 && phase != 4);
            send_item(1'b0, rand64(), rand64(), rand64(), rand64());
            for (int n = 0; n < 50; n++) random_item(10);
            drain();
        end
        gaps_on = 1'b1;

        $display("Ran %0d blocks and %0d chain loads over several keys, generators and both",
                 blocks_sent, loads_sent);
        $display("directions; %0d results compared.", blocks_checked);
        if (fail_count == 0 && blocks_pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/r256cbc_pkg.sv
src/r256cbc_ctrl.sv
src/r256cbc_datapath.sv
src/rijndael256_cbc_block_cipher.sv
tb/r256cbc_checker.sv
tb/tb.sv
